// ===== rtl/semr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the Sobel edge magnitude unit.
// No dependencies.
package semr_pkg;

    // one RGB pixel, red in the top byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one column of the 3x3 window, top row first
    typedef struct packed {
        t_rgb up;
        t_rgb mid;
        t_rgb low;
    } t_col;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // configuration register indexes
    typedef logic [0:0] t_cfg_addr;
    localparam t_cfg_addr CFG_IMAGE_WIDTH  = 1'b0;
    localparam t_cfg_addr CFG_IMAGE_HEIGHT = 1'b1;
    localparam int unsigned CFG_DATA_W = 11;

    localparam int unsigned PIX_W  = 24;
    localparam int unsigned GRAD_W = 11;
    localparam int unsigned SUM_W  = 21;
    // smallest gx^2+gy^2 whose rounded root exceeds 255
    localparam logic [SUM_W-1:0] SUM_SAT = 21'd65281;
    localparam logic [7:0]       MAG_MAX = 8'd255;

    // partial state of the digit-by-digit square root
    typedef struct packed {
        logic [8:0] rem;
        logic [7:0] root;
    } t_sq;

    function automatic logic [7:0] ch_of(t_rgb p, t_chan c);
        logic [7:0] v;
        case (c)
            CH_RED:   v = p.red;
            CH_GREEN: v = p.green;
            default:  v = p.blue;
        endcase
        return v;
    endfunction

    // (q0 + 2*q1 + q2) - (p0 + 2*p1 + p2)
    function automatic logic signed [GRAD_W-1:0] sobel_diff(
        logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
        logic [7:0] q0, logic [7:0] q1, logic [7:0] q2);
        logic [9:0] sp;
        logic [9:0] sq;
        sp = {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
        sq = {2'b00, q0} + {1'b0, q1, 1'b0} + {2'b00, q2};
        return $signed({1'b0, sq}) - $signed({1'b0, sp});
    endfunction

    // one root bit: bring down two radicand bits, try (root*4+1)
    function automatic t_sq sqrt_step(t_sq st, logic [1:0] pair);
        logic [10:0] rem_sh;
        logic [10:0] trial;
        t_sq         res;
        rem_sh = {st.rem, pair};
        trial  = {1'b0, st.root, 2'b01};
        if (rem_sh >= trial) begin
            res.rem  = 9'(rem_sh - trial);
            res.root = {st.root[6:0], 1'b1};
        end else begin
            res.rem  = 9'(rem_sh);
            res.root = {st.root[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/semr_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module semr_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sobel_edge_magnitude_rgb_unit.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 Sobel edge magnitude on RGB pixels, top level.
// Depends on semr_pkg and semr_ram.
//
// Usage:
//  - Slave stream: one RGB pixel per transaction in raster order; tuser = 1 marks a
//    drain item. After the frame's last pixel send image_width+1 drain items; a
//    drain item sent while pixels are still expected is taken and dropped, a pixel
//    sent while drain items are expected acts as a drain.
//  - Master stream: one edge magnitude per channel, round(sqrt(gx^2+gy^2))
//    saturated at 255; tlast flags the frame's final result. A result belongs to
//    the pixel one line plus one pixel before the item that pushes it out.
//  - Config port: write image_width (index 0) or image_height (index 1) while the
//    block is idle; any write restarts the frame. 0 acts as 1, values above
//    MAX_WIDTH / MAX_HEIGHT act as the maximum.
//  - Throughput: one item per clock while the output is not stalled. The two line
//    stores share one RAM entry per column that is read at accept and written back
//    when the item leaves the window stage; a same-column read right behind the
//    write is served from a forwarding register.
//  - Pipeline: a result passes RAM read, window, gradients, squares and two root
//    halves before it leaves the output register.
//  - Stall: a low m_axis_tready freezes the whole pipeline only while the output
//    register holds an untaken result, and s_axis_tready drops in the same cycle.
//  - Reset: counters and pipeline valids clear, width and height return to 1024
//    (or the maximum); line store contents stay undefined, masked on use.
module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic [0:0]                      i_s_axis_tuser,  // drain
    // master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [23:0]                     o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic                            o_m_axis_tlast,  // frame_last
    // configuration
    input  logic                            i_cfg_we,
    input  semr_pkg::t_cfg_addr             i_cfg_addr,
    input  logic [semr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT + 2);
    localparam int RST_W  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H  = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
    localparam int LINE_W = 2 * semr_pkg::PIX_W;

    // ---------------------------------------------------------------- control regs
    logic [CW-1:0] r_wlast;   // clamped width minus one
    logic [RW-1:0] r_hgt;     // clamped height
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic [CW-1:0] cfg_wlast;
    logic [RW-1:0] cfg_hgt;

    // pipeline advance: output register free or being taken
    logic ce;
    assign ce              = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // clamp written dimensions once, at the write
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_wlast = '0;
        end else if (32'(i_cfg_wdata) > 32'(MAX_WIDTH)) begin
            cfg_wlast = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_wlast = CW'(i_cfg_wdata - 11'd1);
        end
        if (i_cfg_wdata == '0) begin
            cfg_hgt = RW'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_HEIGHT)) begin
            cfg_hgt = RW'(MAX_HEIGHT);
        end else begin
            cfg_hgt = RW'(i_cfg_wdata);
        end
    end

    // ---------------------------------------------------------------- stage A: accept
    logic          pix_phase, drop, acc, acc_item;
    logic          a_x0, a_ge1, a_ge2, a_emit, a_last;
    semr_pkg::t_rgb a_pix;

    always_comb begin
        pix_phase = r_row < r_hgt;
        // drop a drain item while pixels are still expected
        drop      = pix_phase && i_s_axis_tuser[0];
        acc       = i_s_axis_tvalid && ce;
        acc_item  = acc && !drop;
        a_x0      = r_col == '0;
        a_ge1     = r_row != '0;
        a_ge2     = r_row > RW'(1);
        a_last    = a_x0 && (r_row == RW'(r_hgt + RW'(1)));
        a_emit    = a_x0 ? a_ge2 : a_ge1;
        if (pix_phase) begin
            a_pix.red   = i_s_axis_tdata[7:0];
            a_pix.green = i_s_axis_tdata[15:8];
            a_pix.blue  = i_s_axis_tdata[23:16];
        end else begin
            a_pix = '0;
        end

        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (acc_item) begin
            if (a_last) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == r_wlast) begin
                n_col = '0;
                n_row = RW'(r_row + RW'(1));
            end else begin
                n_col = CW'(r_col + CW'(1));
            end
        end
    end

    // ---------------------------------------------------------------- line store RAM
    // entry = {upper line, middle line} of one column
    logic              ram_we;
    logic [LINE_W-1:0] ram_wdata, ram_rdata;
    logic              r_fwd_hit;
    logic [LINE_W-1:0] r_fwd_data;

    // stage B registers
    logic           r_b_vld, r_b_x0, r_b_ge1, r_b_ge2, r_b_emit, r_b_last;
    logic [CW-1:0]  r_b_x;
    semr_pkg::t_rgb r_b_pix;

    semr_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_x),
        .i_wdata (ram_wdata),
        .i_re    (acc_item),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- stage B: window
    semr_pkg::t_col r_wc1, r_wc2;        // window columns kept between items
    semr_pkg::t_col n_wc1, b_col, b_e2;
    semr_pkg::t_rgb b_up_raw, b_mid_raw;
    logic [LINE_W-1:0] b_line;

    always_comb begin
        // take the pending write when it hit the column just read
        b_line    = r_fwd_hit ? r_fwd_data : ram_rdata;
        b_up_raw  = b_line[LINE_W-1:semr_pkg::PIX_W];
        b_mid_raw = b_line[semr_pkg::PIX_W-1:0];
        // mask lines above the frame's top
        b_col.up  = r_b_ge2 ? b_up_raw : '0;
        b_col.mid = r_b_ge1 ? b_mid_raw : '0;
        b_col.low = r_b_pix;
        // column zero closes the previous line with a zero column
        b_e2      = r_b_x0 ? '0 : b_col;
        n_wc1     = r_b_x0 ? '0 : r_wc2;
        ram_we    = ce && r_b_vld;
        ram_wdata = {b_mid_raw, r_b_pix};
    end

    // stage C: emitted window
    logic           r_c_vld, r_c_last;
    semr_pkg::t_col r_c_e0, r_c_e1, r_c_e2;

    // stage D: gradients
    logic                                r_d_vld, r_d_last;
    logic signed [semr_pkg::GRAD_W-1:0]  r_d_gx [3];
    logic signed [semr_pkg::GRAD_W-1:0]  r_d_gy [3];
    logic signed [semr_pkg::GRAD_W-1:0]  c_gx [3];
    logic signed [semr_pkg::GRAD_W-1:0]  c_gy [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            c_gx[ch] = semr_pkg::sobel_diff(
                semr_pkg::ch_of(r_c_e0.up,  semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e0.mid, semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e0.low, semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e2.up,  semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e2.mid, semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e2.low, semr_pkg::t_chan'(ch)));
            c_gy[ch] = semr_pkg::sobel_diff(
                semr_pkg::ch_of(r_c_e0.up,  semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e1.up,  semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e2.up,  semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e0.low, semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e1.low, semr_pkg::t_chan'(ch)),
                semr_pkg::ch_of(r_c_e2.low, semr_pkg::t_chan'(ch)));
        end
    end

    // stage E: sum of squares
    logic                       r_e_vld, r_e_last;
    logic [semr_pkg::SUM_W-1:0] r_e_sum [3];
    logic [semr_pkg::SUM_W-1:0] d_sum [3];
    logic signed [2*semr_pkg::GRAD_W-1:0] d_sqx [3];
    logic signed [2*semr_pkg::GRAD_W-1:0] d_sqy [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            d_sqx[ch] = r_d_gx[ch] * r_d_gx[ch];
            d_sqy[ch] = r_d_gy[ch] * r_d_gy[ch];
            d_sum[ch] = semr_pkg::SUM_W'(d_sqx[ch]) + semr_pkg::SUM_W'(d_sqy[ch]);
        end
    end

    // stage F: upper four root bits
    logic            r_f_vld, r_f_last;
    logic            r_f_sat [3];
    logic [7:0]      r_f_lo  [3];
    semr_pkg::t_sq   r_f_st  [3];
    semr_pkg::t_sq   e_st    [3];
    logic            e_sat   [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            e_sat[ch] = r_e_sum[ch] >= semr_pkg::SUM_SAT;
            e_st[ch]  = '0;
            for (int i = 0; i < 4; i++) begin
                e_st[ch] = semr_pkg::sqrt_step(e_st[ch], r_e_sum[ch][15 - 2*i -: 2]);
            end
        end
    end

    // output stage: lower four root bits, round, saturate
    logic           r_o_vld, r_o_last;
    semr_pkg::t_rgb r_o_px;
    semr_pkg::t_sq  f_st  [3];
    logic [8:0]     f_rnd [3];
    logic [7:0]     f_mag [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            f_st[ch] = r_f_st[ch];
            for (int i = 0; i < 4; i++) begin
                f_st[ch] = semr_pkg::sqrt_step(f_st[ch], r_f_lo[ch][7 - 2*i -: 2]);
            end
            // round up when the remainder exceeds the root
            f_rnd[ch] = {1'b0, f_st[ch].root} +
                        9'(f_st[ch].rem > {1'b0, f_st[ch].root});
            if (r_f_sat[ch] || f_rnd[ch][8]) begin
                f_mag[ch] = semr_pkg::MAG_MAX;
            end else begin
                f_mag[ch] = f_rnd[ch][7:0];
            end
        end
    end

    // ---------------------------------------------------------------- control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= CW'(RST_W - 1);
            r_hgt   <= RW'(RST_H);
            r_col   <= '0;
            r_row   <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    semr_pkg::CFG_IMAGE_WIDTH:  r_wlast <= cfg_wlast;
                    semr_pkg::CFG_IMAGE_HEIGHT: r_hgt   <= cfg_hgt;
                    default: ;
                endcase
            end
            if (ce) begin
                r_b_vld <= acc_item;
                r_c_vld <= r_b_vld && r_b_emit;
                r_d_vld <= r_c_vld;
                r_e_vld <= r_d_vld;
                r_f_vld <= r_e_vld;
                r_o_vld <= r_f_vld;
            end
        end
    end

    // ---------------------------------------------------------------- payload flops
    always_ff @(posedge i_clk) begin
        if (acc_item) begin
            r_b_x      <= r_col;
            r_b_x0     <= a_x0;
            r_b_ge1    <= a_ge1;
            r_b_ge2    <= a_ge2;
            r_b_emit   <= a_emit;
            r_b_last   <= a_last;
            r_b_pix    <= a_pix;
            r_fwd_hit  <= ram_we && (r_b_x == r_col);
            r_fwd_data <= ram_wdata;
        end
        if (ram_we) begin
            r_wc1 <= n_wc1;
            r_wc2 <= b_col;
        end
        if (ce) begin
            r_c_last <= r_b_last;
            r_c_e0   <= r_wc1;
            r_c_e1   <= r_wc2;
            r_c_e2   <= b_e2;
            r_d_last <= r_c_last;
            r_e_last <= r_d_last;
            r_f_last <= r_e_last;
            r_o_last <= r_f_last;
            for (int ch = 0; ch < 3; ch++) begin
                r_d_gx[ch]  <= c_gx[ch];
                r_d_gy[ch]  <= c_gy[ch];
                r_e_sum[ch] <= d_sum[ch];
                r_f_sat[ch] <= e_sat[ch];
                r_f_lo[ch]  <= r_e_sum[ch][7:0];
                r_f_st[ch]  <= e_st[ch];
            end
            r_o_px.red   <= f_mag[0];
            r_o_px.green <= f_mag[1];
            r_o_px.blue  <= f_mag[2];
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_px.blue, r_o_px.green, r_o_px.red};
    assign o_m_axis_tlast  = r_o_last;

`ifndef NO_ASSERTIONS
    // position stays inside the frame plus its two drain rows
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wlast)
        else $error("column counter past line end");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(r_hgt + RW'(1)))
        else $error("row counter past drain rows");

    // the flagged item restarts the frame position
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_item && a_last) |=> (r_col == '0 && r_row == '0))
        else $error("frame did not restart after last item");

    // a frozen window stage keeps its item and its RAM read data
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ce && r_b_vld) |=> (r_b_vld && $stable(ram_rdata)))
        else $error("stage B item or RAM data lost during stall");

    // a frame end is always carried by an emitting item
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_b_last) |-> r_b_emit)
        else $error("frame end on a non-emitting item");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_rgb_unit: RGB pixel stream in, per-channel
// Sobel magnitudes out, compared against an in-bench frame predictor.
// Depends on semr_pkg and the RTL of the unit.
module tb;
    import semr_pkg::*;

    localparam int MAX_SIDE      = 1024;
    localparam int SAT_LEVEL     = 255;
    localparam int SAT_SUM       = 65281;   // smallest gx^2+gy^2 that rounds above 255
    localparam int SETTLE_CYCLES = 16;      // pipeline depth plus margin
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 900;

    // one expected result transaction
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } edge_rgb_t;

    // DUT connections; every input starts at a known value
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata  = '0;  // red_in, green_in, blue_in
    logic [0:0]            i_s_axis_tuser  = '0;  // drain
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;        // red_out, green_out, blue_out
    logic                  o_m_axis_tlast;        // frame_last
    logic                  i_cfg_we        = 1'b0;
    t_cfg_addr             i_cfg_addr      = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;

    // predictor state: register copies, two line buffers, 3x3 window, frame position
    logic [10:0] frame_w_reg = 11'd1024;
    logic [10:0] frame_h_reg = 11'd1024;
    t_rgb        prev2_line [MAX_SIDE];
    t_rgb        prev1_line [MAX_SIDE];
    t_rgb        sobel_win  [3][3];
    int          next_col;
    int          next_row;
    logic [19:0] frame_results;

    edge_rgb_t   pending_edges [$];

    int fail_count  = 0;
    int items_taken = 0;

    // traffic shaping knobs, changed by the tests
    bit src_gappy     = 1'b0;
    bit sink_gappy    = 1'b0;
    int sink_hold_req = 0;

    sobel_edge_magnitude_rgb_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int fit_side(logic [10:0] v);
        if (v == 11'd0) return 1;
        return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic void start_new_frame();
        foreach (sobel_win[i, j]) sobel_win[i][j] = '0;
        next_col      = 0;
        next_row      = 0;
        frame_results = '0;
    endfunction

    // advance the window one column: oldest column drops out on the left
    function automatic void push_column(t_rgb up, t_rgb mid, t_rgb low);
        for (int i = 0; i < 3; i++) begin
            sobel_win[i][0] = sobel_win[i][1];
            sobel_win[i][1] = sobel_win[i][2];
        end
        sobel_win[0][2] = up;
        sobel_win[1][2] = mid;
        sobel_win[2][2] = low;
    endfunction

    // rounded sqrt(gx^2+gy^2) of one channel; sh selects the byte of the pixel
    function automatic logic [7:0] edge_strength(int sh);
        int          v [3][3];
        logic [23:0] bits;
        int          gx;
        int          gy;
        int          sq;
        int          root;
        foreach (sobel_win[i, j]) begin
            bits    = sobel_win[i][j];
            v[i][j] = int'(bits[sh +: 8]);
        end
        gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
        gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
        sq = gx * gx + gy * gy;
        if (sq >= SAT_SUM) return 8'(SAT_LEVEL);
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        // round half up; the remainder test is exact, no tie is possible
        if (sq - root * root > root) root++;
        return (root > SAT_LEVEL) ? 8'(SAT_LEVEL) : 8'(root);
    endfunction

    function automatic void log_edge(bit is_final);
        edge_rgb_t e;
        e.red       = edge_strength(16);
        e.green     = edge_strength(8);
        e.blue      = edge_strength(0);
        e.frame_end = is_final;
        pending_edges.push_back(e);
        frame_results++;
    endfunction

    // update the predictor with one accepted input transaction
    function automatic void advance_edge_window(t_rgb px, bit drain);
        int   w;
        int   h;
        int   x;
        t_rgb pix;
        t_rgb up;
        t_rgb mid;
        bit   is_final;
        w   = fit_side(frame_w_reg);
        h   = fit_side(frame_h_reg);
        x   = next_col;
        pix = '0;
        if (next_row < h) begin
            // drain while pixels are still expected: dropped without effect
            if (drain) return;
            pix = px;
        end
        // past the last pixel every item acts as a drain with zero colour
        if (x >= w) x = 0;

        up  = (next_row >= 2) ? prev2_line[x] : '0;
        mid = (next_row >= 1) ? prev1_line[x] : '0;
        prev2_line[x] = prev1_line[x];
        prev1_line[x] = pix;

        if (x == 0) begin
            // first column: flush the right-edge result of the line above
            if (next_row >= 2) begin
                is_final = (next_row == h + 1);
                push_column('0, '0, '0);
                log_edge(is_final);
                if (is_final) begin
                    start_new_frame();
                    return;
                end
            end
            foreach (sobel_win[i, j]) sobel_win[i][j] = '0;
            sobel_win[0][2] = up;
            sobel_win[1][2] = mid;
            sobel_win[2][2] = pix;
        end else begin
            push_column(up, mid, pix);
            if (next_row >= 1) log_edge(1'b0);
        end

        x++;
        if (x >= w) begin
            x        = 0;
            next_row = (next_row + 1) & 'h7FF;
        end
        next_col = x & 'h3FF;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // result side: check every accepted transaction, then pick the next tready
    initial begin : result_sink
        int        stall_left;
        edge_rgb_t got;
        edge_rgb_t want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tdata[23:16],
                       o_m_axis_tlast};
                if (pending_edges.size() == 0) begin
                    note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d last=%b",
                                           got.red, got.green, got.blue, got.frame_end));
                end else begin
                    want = pending_edges.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                        note_failure($sformatf(
                            "expected r=%0d g=%0d b=%0d last=%b, got r=%0d g=%0d b=%0d last=%b",
                            want.red, want.green, want.blue, want.frame_end,
                            got.red, got.green, got.blue, got.frame_end));
                    end
                end
            end
            if (!i_rst_n) begin
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (sink_hold_req > 0) begin
                // long hold-off requested by a test: count it out here
                stall_left    = sink_hold_req - 1;
                sink_hold_req = 0;
                i_m_axis_tready <= 1'b0;
            end else if (!sink_gappy || $urandom_range(0, 99) < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 3);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // style 0: full random, 1: each channel 0 or 255, 2: low contrast for rounding
    function automatic t_rgb make_pixel(int style);
        t_rgb p;
        case (style)
            1: begin
                p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
                p.red   = 8'($urandom_range(100, 107));
                p.green = 8'($urandom_range(0, 5));
                p.blue  = 8'($urandom_range(250, 255));
            end
            default: begin
                p = t_rgb'($urandom_range(0, 24'hFFFFFF));
            end
        endcase
        return p;
    endfunction

    // send one input transaction; called right after a rising edge, returns on acceptance
    task automatic push_pixel(input t_rgb px, input bit drain);
        int gap;
        int r;
        gap = 0;
        if (src_gappy) begin
            r   = $urandom_range(0, 99);
            gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {px.blue, px.green, px.red};
        i_s_axis_tuser  <= drain;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_taken++;
        advance_edge_window(px, drain);
    endtask

    // drop valid, wait for every expected result, then let the pipeline run empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both size registers on consecutive edges; each write restarts the frame
    task automatic set_frame_size(input logic [10:0] w, input logic [10:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_IMAGE_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        frame_w_reg = w;
        start_new_frame();
        i_cfg_addr  <= CFG_IMAGE_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        frame_h_reg = h;
        start_new_frame();
        i_cfg_we <= 1'b0;
    endtask

    // one full frame: w*h pixels then w+1 drains; noisy adds stray drains and
    // pixels in the drain phase
    task automatic run_frame(input int w, input int h, input int style, input bit noisy);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (noisy && $urandom_range(0, 7) == 0) push_pixel(make_pixel(0), 1'b1);
                push_pixel(make_pixel(style), 1'b0);
            end
        end
        for (int k = 0; k <= w; k++) begin
            push_pixel(make_pixel(0), !(noisy && $urandom_range(0, 3) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // black, white and mixed pixels on a 3x2 frame: saturation and all-zero windows
    task automatic test_extreme_pixels();
        settle();
        src_gappy  = 1'b0;
        sink_gappy = 1'b0;
        set_frame_size(11'd3, 11'd2);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'hFF0080, 1'b0);
        push_pixel(24'hFFFFFF, 1'b0);
        push_pixel(24'h000000, 1'b0);
        push_pixel(24'h01FE7F, 1'b0);
        for (int k = 0; k < 4; k++) push_pixel((k % 2) ? 24'hFFFFFF : 24'h000000, 1'b1);
    endtask

    // stray drain among pixels, pixel among drains, then a second frame with no rewrite
    task automatic test_drain_swaps();
        settle();
        set_frame_size(11'd2, 11'd1);
        push_pixel(24'h102030, 1'b0);
        push_pixel(24'hFFFFFF, 1'b1);   // dropped
        push_pixel(24'h405060, 1'b0);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'hABCDEF, 1'b0);   // acts as a drain
        push_pixel(24'h000000, 1'b1);   // flagged result
        push_pixel(24'hC0FFEE, 1'b0);
        push_pixel(24'h5A5A5A, 1'b0);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'h000000, 1'b1);
    endtask

    // zero in both registers acts as a 1x1 frame
    task automatic test_zero_size();
        settle();
        set_frame_size(11'd0, 11'd0);
        push_pixel(24'h123456, 1'b0);
        push_pixel(24'h000000, 1'b1);
        push_pixel(24'h000000, 1'b1);
    endtask

    // all-ones register values clamp to the maximum width and height
    task automatic test_size_extremes();
        settle();
        src_gappy  = 1'b1;
        sink_gappy = 1'b1;
        set_frame_size(11'h7FF, 11'd1);
        run_frame(MAX_SIDE, 1, 0, 1'b0);
        settle();
        set_frame_size(11'd1, 11'h7FF);
        run_frame(1, MAX_SIDE, 1, 1'b0);
    endtask

    // abandon a frame halfway: the register write must restart position and window
    task automatic test_restart_mid_frame();
        settle();
        set_frame_size(11'd5, 11'd4);
        for (int k = 0; k < 8; k++) push_pixel(make_pixel(0), 1'b0);
        settle();
        set_frame_size(11'd5, 11'd4);
        run_frame(5, 4, 0, 1'b0);
    endtask

    // hold tready low for a long stretch while the source keeps offering back to back
    task automatic test_stalled_output();
        settle();
        src_gappy  = 1'b0;
        sink_gappy = 1'b0;
        set_frame_size(11'd8, 11'd6);
        sink_hold_req = 300;
        run_frame(8, 6, 0, 1'b0);
    endtask

    // mostly small random frames, with back-to-back frames, noise and changing traffic
    task automatic test_random_frames();
        int          start;
        int          cur_w;
        int          cur_h;
        int          r;
        logic [10:0] w_reg;
        logic [10:0] h_reg;
        start = items_taken;
        cur_w = 0;
        cur_h = 0;
        while (items_taken - start < RANDOM_ITEMS) begin
            if (cur_w == 0 || $urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    w_reg = 11'($urandom_range(1, 12));
                    h_reg = 11'($urandom_range(1, 8));
                end else if (r < 95) begin
                    w_reg = 11'($urandom_range(13, 40));
                    h_reg = 11'($urandom_range(1, 12));
                end else begin
                    w_reg = 11'($urandom_range(41, 100));
                    h_reg = 11'($urandom_range(1, 3));
                end
                if ($urandom_range(0, 19) == 0) w_reg = 11'd0;
                if ($urandom_range(0, 19) == 0) h_reg = 11'd0;
                settle();
                set_frame_size(w_reg, h_reg);
                cur_w = fit_side(w_reg);
                cur_h = fit_side(h_reg);
            end
            src_gappy  = ($urandom_range(0, 3) != 0);
            sink_gappy = ($urandom_range(0, 3) != 0);
            run_frame(cur_w, cur_h, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin : main_sequence
        foreach (prev2_line[i]) begin
            prev2_line[i] = '0;
            prev1_line[i] = '0;
        end
        start_new_frame();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_pixels();
        test_drain_swaps();
        test_zero_size();
        test_size_extremes();
        test_restart_mid_frame();
        test_stalled_output();
        test_random_frames();

        // drain everything with tready high, then look for stray results
        sink_gappy = 1'b0;
        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (pending_edges.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", pending_edges.size()));
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/semr_pkg.sv
rtl/semr_ram.sv
rtl/sobel_edge_magnitude_rgb_unit.sv
dv/tb.sv
